FILE: hw/rtl/c2d_pkg.sv
`default_nettype none

package c2d_pkg;

    // Default geometry of the stores.
    localparam int C2D_MAX_CHANNELS = 16;
    localparam int C2D_MAX_DIM      = 32;
    localparam int C2D_MAX_KERNEL   = 5;

    // Field widths of the words on the two channels.
    localparam int C2D_CMD_W  = 2;
    localparam int C2D_ADDR_W = 14;
    localparam int C2D_DATA_W = 16;
    localparam int C2D_OC_W   = 4;
    localparam int C2D_POS_W  = 5;

    // Configuration port.
    localparam int C2D_CFG_IDX_W  = 3;
    localparam int C2D_CFG_DATA_W = 6;
    localparam int C2D_SHIFT_W    = 5;

    typedef enum logic [C2D_CMD_W-1:0] {
        CMD_LOAD_ACT  = 2'd0,
        CMD_LOAD_WGT  = 2'd1,
        CMD_LOAD_BIAS = 2'd2,
        CMD_COMPUTE   = 2'd3
    } c2d_cmd_e;

    typedef enum logic [C2D_CFG_IDX_W-1:0] {
        REG_IN_DEPTH    = 3'd0,
        REG_OUT_DEPTH   = 3'd1,
        REG_OUT_HEIGHT  = 3'd2,
        REG_OUT_WIDTH   = 3'd3,
        REG_KERN_HEIGHT = 3'd4,
        REG_KERN_WIDTH  = 3'd5,
        REG_RELU_ENABLE = 3'd6,
        REG_FRAC_SHIFT  = 3'd7
    } c2d_reg_e;

    typedef struct packed {
        logic [C2D_CMD_W-1:0]         command;
        logic [C2D_ADDR_W-1:0]        address;
        logic signed [C2D_DATA_W-1:0] value;
        logic [C2D_OC_W-1:0]          out_channel;
        logic [C2D_POS_W-1:0]         out_row;
        logic [C2D_POS_W-1:0]         out_col;
    } c2d_in_t;

    typedef struct packed {
        logic signed [C2D_DATA_W-1:0] result_value;
        logic                         bad_request;
    } c2d_out_t;

    // Control from the sequencer to the multiply-accumulate unit.
    typedef struct packed {
        logic                   clear;
        logic                   tap_valid;
        logic [C2D_SHIFT_W-1:0] shift;
    } c2d_mac_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/c2d_mac.sv
`default_nettype none

module c2d_mac
    import c2d_pkg::*;
(
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire c2d_mac_ctl_t                 ctl,
    input  wire logic signed [C2D_DATA_W-1:0] act,
    input  wire logic signed [C2D_DATA_W-1:0] wgt,
    output logic signed [C2D_DATA_W-1:0]      acc
);

    logic signed [2*C2D_DATA_W-1:0] prod_reg;
    logic                           prod_vld_reg;
    logic signed [2*C2D_DATA_W-1:0] shifted;
    logic signed [C2D_DATA_W-1:0]   acc_reg;

    // Each product is shifted arithmetically, then only its low half is summed.
    assign shifted = prod_reg >>> ctl.shift;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
        end else begin
            prod_vld_reg <= ctl.tap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= act * wgt;
        if (ctl.clear) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + shifted[C2D_DATA_W-1:0];
        end
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/conv2d_fixed_point_relu_top.sv
// Single-output 2-D convolution engine (stride 1, no padding) over int16 fixed-point data.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata while the engine is idle.
// Each word on the s_ channel is a command. Load commands write one entry of the activation,
// weight or bias store; they produce no result word. A compute command names an output
// channel, row and column and produces exactly one m_ word.
// A compute walks in_depth x kern_height x kern_width taps, one tap per cycle through a
// single shared multiplier, shifter and 16-bit accumulator. After the loop over taps the
// last tap passes the memory read, product and accumulate stages, and the bias is added as
// the result is loaded into the output register; an out-of-range request skips the loop.
// The tap loop bounds the time a compute takes: at most 16 x 25 = 400 taps.
// s_ready is high only while the sequencer is idle. A finished result sits in the output
// register; loads keep flowing while it waits, but the next compute holds its result until
// the receiver has taken the previous one.
// aresetn is synchronous and active low. It restores the configuration defaults and empties
// the output register. The stores are not cleared; entries are valid once written.

`default_nettype none

module conv2d_fixed_point_relu_top
    import c2d_pkg::*;
#(
    parameter int MAX_CHANNELS = C2D_MAX_CHANNELS,
    parameter int MAX_DIM      = C2D_MAX_DIM,
    parameter int MAX_KERNEL   = C2D_MAX_KERNEL
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [C2D_CFG_IDX_W-1:0]  cfg_addr,
    input  wire logic [C2D_CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire c2d_in_t                   s_payload,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output c2d_out_t                       m_payload
);

    localparam int ACT_DEPTH  = MAX_CHANNELS * MAX_DIM * MAX_DIM;
    localparam int WGT_DEPTH  = MAX_CHANNELS * MAX_CHANNELS * MAX_KERNEL * MAX_KERNEL;
    localparam int ACT_AW     = (ACT_DEPTH > 1) ? $clog2(ACT_DEPTH) : 1;
    localparam int WGT_AW     = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;
    localparam int BIAS_AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    // Loop counters are wide enough to hold their limit itself.
    localparam int CL_W       = $clog2(MAX_CHANNELS + 1);
    localparam int KL_W       = $clog2(MAX_KERNEL + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RUN    = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // Configuration registers.
    logic [4:0]             in_depth_reg;
    logic [4:0]             out_depth_reg;
    logic [5:0]             out_height_reg;
    logic [5:0]             out_width_reg;
    logic [2:0]             kern_height_reg;
    logic [2:0]             kern_width_reg;
    logic                   relu_enable_reg;
    logic [C2D_SHIFT_W-1:0] frac_shift_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_depth_reg    <= 5'd1;
            out_depth_reg   <= 5'd1;
            out_height_reg  <= 6'd1;
            out_width_reg   <= 6'd1;
            kern_height_reg <= 3'd1;
            kern_width_reg  <= 3'd1;
            relu_enable_reg <= 1'b0;
            frac_shift_reg  <= 5'd8;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_IN_DEPTH:    in_depth_reg    <= cfg_wdata[4:0];
                REG_OUT_DEPTH:   out_depth_reg   <= cfg_wdata[4:0];
                REG_OUT_HEIGHT:  out_height_reg  <= cfg_wdata[5:0];
                REG_OUT_WIDTH:   out_width_reg   <= cfg_wdata[5:0];
                REG_KERN_HEIGHT: kern_height_reg <= cfg_wdata[2:0];
                REG_KERN_WIDTH:  kern_width_reg  <= cfg_wdata[2:0];
                REG_RELU_ENABLE: relu_enable_reg <= cfg_wdata[0];
                REG_FRAC_SHIFT:  frac_shift_reg  <= cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer and per-request registers.
    state_t          state_reg, state_next;
    logic [CL_W-1:0] ic_reg, ic_next;
    logic [KL_W-1:0] r_reg, r_next;
    logic [KL_W-1:0] c_reg, c_next;
    logic            drain_reg, drain_next;
    logic            m_valid_reg, m_valid_next;
    logic [CL_W-1:0] ind_lim_reg;
    logic [KL_W-1:0] kh_lim_reg;
    logic [KL_W-1:0] kw_lim_reg;
    logic [C2D_OC_W-1:0]  oc_reg;
    logic [C2D_POS_W-1:0] orow_reg;
    logic [C2D_POS_W-1:0] ocol_reg;
    logic            bad_reg;
    logic signed [C2D_DATA_W-1:0] bias_q_reg;
    logic signed [C2D_DATA_W-1:0] act_q_reg;
    logic signed [C2D_DATA_W-1:0] wgt_q_reg;
    logic            tap_vld_reg;
    c2d_out_t        m_payload_reg;

    logic            in_accept;
    logic            is_compute;
    logic            req_bad;
    logic [CL_W-1:0] ind_lim;
    logic [KL_W-1:0] kh_lim;
    logic [KL_W-1:0] kw_lim;
    logic            no_taps;
    logic            c_last;
    logic            r_last;
    logic            ic_last;
    int              ar_i;
    int              ac_i;
    logic            in_window;
    logic [ACT_AW-1:0]  act_raddr;
    logic [WGT_AW-1:0]  wgt_raddr;
    logic [ACT_AW-1:0]  act_waddr;
    logic [WGT_AW-1:0]  wgt_waddr;
    logic [BIAS_AW-1:0] bias_waddr;
    logic [BIAS_AW-1:0] bias_raddr;
    logic            out_load;
    logic signed [C2D_DATA_W-1:0] acc;
    logic signed [C2D_DATA_W-1:0] biased;
    c2d_mac_ctl_t    mac_ctl;

    assign s_ready    = (state_reg == ST_IDLE);
    assign in_accept  = s_valid && s_ready;
    assign is_compute = (s_payload.command == CMD_COMPUTE);

    // Positions beyond the configured output size, or beyond the stores, are rejected.
    assign req_bad = (int'(s_payload.out_channel) >= int'(out_depth_reg))
                  || (int'(s_payload.out_channel) >= MAX_CHANNELS)
                  || (int'(s_payload.out_row) >= int'(out_height_reg))
                  || (int'(s_payload.out_row) >= MAX_DIM)
                  || (int'(s_payload.out_col) >= int'(out_width_reg))
                  || (int'(s_payload.out_col) >= MAX_DIM);

    // Oversized loop settings saturate at the store geometry.
    assign ind_lim = (int'(in_depth_reg) > MAX_CHANNELS) ? CL_W'(MAX_CHANNELS)
                                                         : CL_W'(in_depth_reg);
    assign kh_lim  = (int'(kern_height_reg) > MAX_KERNEL) ? KL_W'(MAX_KERNEL)
                                                          : KL_W'(kern_height_reg);
    assign kw_lim  = (int'(kern_width_reg) > MAX_KERNEL) ? KL_W'(MAX_KERNEL)
                                                         : KL_W'(kern_width_reg);
    assign no_taps = (ind_lim == '0) || (kh_lim == '0) || (kw_lim == '0);

    assign c_last  = ((c_reg + KL_W'(1)) == kw_lim_reg);
    assign r_last  = ((r_reg + KL_W'(1)) == kh_lim_reg);
    assign ic_last = ((ic_reg + CL_W'(1)) == ind_lim_reg);

    // Tap addressing. A tap whose activation falls past the stored rows or columns
    // contributes nothing, so it is simply not marked valid.
    assign ar_i      = int'(orow_reg) + int'(r_reg);
    assign ac_i      = int'(ocol_reg) + int'(c_reg);
    assign in_window = (ar_i < MAX_DIM) && (ac_i < MAX_DIM);
    assign act_raddr = ACT_AW'((int'(ic_reg) * MAX_DIM + ar_i) * MAX_DIM + ac_i);
    assign wgt_raddr = WGT_AW'(((int'(oc_reg) * MAX_CHANNELS + int'(ic_reg)) * MAX_KERNEL
                                + int'(r_reg)) * MAX_KERNEL + int'(c_reg));

    assign act_waddr  = ACT_AW'(s_payload.address);
    assign wgt_waddr  = WGT_AW'(s_payload.address);
    assign bias_waddr = BIAS_AW'(s_payload.address);
    assign bias_raddr = BIAS_AW'(s_payload.out_channel);

    always_comb begin
        state_next   = state_reg;
        ic_next      = ic_reg;
        r_next       = r_reg;
        c_next       = c_reg;
        drain_next   = drain_reg;
        m_valid_next = m_valid_reg;
        out_load     = 1'b0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (in_accept && is_compute) begin
                    ic_next    = '0;
                    r_next     = '0;
                    c_next     = '0;
                    drain_next = 1'b0;
                    if (req_bad) begin
                        state_next = ST_FINISH;
                    end else if (no_taps) begin
                        state_next = ST_DRAIN;
                    end else begin
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                if (c_last) begin
                    c_next = '0;
                    if (r_last) begin
                        r_next = '0;
                        if (ic_last) begin
                            state_next = ST_DRAIN;
                        end else begin
                            ic_next = ic_reg + CL_W'(1);
                        end
                    end else begin
                        r_next = r_reg + KL_W'(1);
                    end
                end else begin
                    c_next = c_reg + KL_W'(1);
                end
            end
            ST_DRAIN: begin
                // The drain state lets the last tap pass the product and accumulate stages.
                drain_next = 1'b1;
                if (drain_reg) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    out_load     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            tap_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            tap_vld_reg <= (state_reg == ST_RUN) && in_window;
        end
    end

    always_ff @(posedge aclk) begin
        ic_reg    <= ic_next;
        r_reg     <= r_next;
        c_reg     <= c_next;
        drain_reg <= drain_next;
        if (in_accept && is_compute) begin
            ind_lim_reg <= ind_lim;
            kh_lim_reg  <= kh_lim;
            kw_lim_reg  <= kw_lim;
            oc_reg      <= s_payload.out_channel;
            orow_reg    <= s_payload.out_row;
            ocol_reg    <= s_payload.out_col;
            bad_reg     <= req_bad;
        end
        if (out_load) begin
            m_payload_reg.bad_request  <= bad_reg;
            m_payload_reg.result_value <= bad_reg ? '0 :
                ((relu_enable_reg && biased[C2D_DATA_W-1]) ? '0 : biased);
        end
    end

    // Stores, each with one write port and a registered read port.
    logic [C2D_DATA_W-1:0] act_mem  [ACT_DEPTH];
    logic [C2D_DATA_W-1:0] wgt_mem  [WGT_DEPTH];
    logic [C2D_DATA_W-1:0] bias_mem [MAX_CHANNELS];

    always_ff @(posedge aclk) begin
        if (in_accept && (s_payload.command == CMD_LOAD_ACT)
            && (int'(s_payload.address) < ACT_DEPTH)) begin
            act_mem[act_waddr] <= s_payload.value;
        end
        act_q_reg <= act_mem[act_raddr];
    end

    always_ff @(posedge aclk) begin
        if (in_accept && (s_payload.command == CMD_LOAD_WGT)
            && (int'(s_payload.address) < WGT_DEPTH)) begin
            wgt_mem[wgt_waddr] <= s_payload.value;
        end
        wgt_q_reg <= wgt_mem[wgt_raddr];
    end

    always_ff @(posedge aclk) begin
        if (in_accept && (s_payload.command == CMD_LOAD_BIAS)
            && (int'(s_payload.address) < MAX_CHANNELS)) begin
            bias_mem[bias_waddr] <= s_payload.value;
        end
        // The bias is fetched when the compute is accepted and held for the whole walk.
        if (in_accept && is_compute) begin
            bias_q_reg <= bias_mem[bias_raddr];
        end
    end

    // The shared multiply, shift and accumulate unit.
    assign mac_ctl.clear     = in_accept && is_compute;
    assign mac_ctl.tap_valid = tap_vld_reg;
    assign mac_ctl.shift     = frac_shift_reg;

    c2d_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .act     (act_q_reg),
        .wgt     (wgt_q_reg),
        .acc     (acc)
    );

    // Bias add wraps at 16 bits like the tap sum.
    assign biased = acc + bias_q_reg;

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

`default_nettype wire
